FILE: src/mdrc_pkg.sv
// ============================================================================
// Motor direction ramp controller package
// Shared types and fixed constants for the motor direction ramp controller.
// ============================================================================
package mdrc_pkg;

    // Payload widths fixed by the command and result formats
    localparam int unsigned REQ_WIDTH   = 16;
    localparam int unsigned DUTY_WIDTH  = 8;
    localparam int unsigned MODE_WIDTH  = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned DELAY_WIDTH = 16;

    typedef logic [MODE_WIDTH-1:0] t_mode;
    typedef logic [DUTY_WIDTH-1:0] t_duty;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    // Motor mode and direction codes
    localparam t_mode MODE_STOP = 2'd0;
    localparam t_mode MODE_FWD  = 2'd1;
    localparam t_mode MODE_BWD  = 2'd2;
    localparam t_mode MODE_BAD  = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_RAMP_UP   = 2'd0;
    localparam t_cfg_idx CFG_RAMP_DOWN = 2'd1;
    localparam t_cfg_idx CFG_REV_DELAY = 2'd2;
    localparam t_cfg_idx CFG_RAMP_INT  = 2'd3;

    // Full-scale duty and register reset values
    localparam t_duty                  DUTY_MAX          = 8'd255;
    localparam t_duty                  RST_RAMP_UP       = 8'd50;
    localparam t_duty                  RST_RAMP_DOWN     = 8'd90;
    localparam logic [DELAY_WIDTH-1:0] RST_REV_DELAY     = 16'd100;
    localparam t_duty                  RST_RAMP_INTERVAL = 8'd40;

endpackage

FILE: src/mdrc_cmd_if.sv
// ============================================================================
// Motor direction ramp controller command channel
// Valid/ready channel carrying one throttle command per transfer.
// ============================================================================
interface mdrc_cmd_if #(
    parameter int unsigned TIME_WIDTH = 32
);
    logic                                 valid;
    logic                                 ready;
    logic signed [mdrc_pkg::REQ_WIDTH-1:0] requested_duty;
    mdrc_pkg::t_mode                      direction;
    logic [TIME_WIDTH-1:0]                now_ms;

    modport source (
        output valid, requested_duty, direction, now_ms,
        input  ready
    );

    modport sink (
        input  valid, requested_duty, direction, now_ms,
        output ready
    );
endinterface

FILE: src/mdrc_res_if.sv
// ============================================================================
// Motor direction ramp controller result channel
// Valid/ready channel carrying the bridge drive state after each command.
// ============================================================================
interface mdrc_res_if;
    logic                  valid;
    logic                  ready;
    mdrc_pkg::t_duty       duty_out;
    logic                  forward_level;
    logic                  backward_level;
    mdrc_pkg::t_mode       motor_mode;

    modport source (
        output valid, duty_out, forward_level, backward_level, motor_mode,
        input  ready
    );

    modport sink (
        input  valid, duty_out, forward_level, backward_level, motor_mode,
        output ready
    );
endinterface

FILE: src/motor_direction_ramp_controller_core.sv
// ============================================================================
// Motor direction ramp controller core
// H-bridge direction control with reversal delay and soft-start duty ramp.
// ============================================================================
// Usage:
// Throttle commands arrive on i_cmd (requested duty, direction, timestamp);
// each transfer yields exactly one result on o_res carrying the duty, the two
// bridge leg levels and the motor mode after that command.
// A command is captured in an input register and then processed into the
// result register, from which o_res offers it. One command is taken every
// cycle while o_res is not stalled: the input register refills while the
// result register is emptied, and this sustained rate is set by the single
// state update step. When the receiver stalls, the result register holds
// its value, the input register keeps the next command and i_cmd.ready
// falls once both are full. Configuration registers are written through
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce this. The synchronous
// active-low reset empties both registers, returns the motor to stop with
// zero duty, clears the time stamps and loads the default ramp steps,
// reversal delay and interval.
// ============================================================================
module motor_direction_ramp_controller_core #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  mdrc_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [mdrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mdrc_cmd_if.sink                            i_cmd,
    mdrc_res_if.source                          o_res
);

    localparam int unsigned DW = mdrc_pkg::DUTY_WIDTH;
    localparam int unsigned PW = 2 * DW;

    // Configuration registers
    mdrc_pkg::t_duty                     r_up_step;
    mdrc_pkg::t_duty                     r_down_step;
    logic [mdrc_pkg::DELAY_WIDTH-1:0]    r_rev_delay;
    mdrc_pkg::t_duty                     r_interval;

    // Input register
    logic                                r_in_valid;
    logic [mdrc_pkg::REQ_WIDTH-1:0]      r_in_req;
    mdrc_pkg::t_mode                     r_in_dir;
    logic [TIME_WIDTH-1:0]               r_in_now;

    // Controller state
    mdrc_pkg::t_mode                     r_mode,       n_mode;
    mdrc_pkg::t_mode                     r_last_dir,   n_last_dir;
    mdrc_pkg::t_duty                     r_duty,       n_duty;
    logic [TIME_WIDTH-1:0]               r_ramp_stamp, n_ramp_stamp;
    logic [TIME_WIDTH-1:0]               r_stop_stamp, n_stop_stamp;
    logic                                r_fwd_pin,    n_fwd_pin;
    logic                                r_bwd_pin,    n_bwd_pin;

    // Result register
    logic                                r_out_valid;
    mdrc_pkg::t_duty                     r_out_duty;
    logic                                r_out_fwd;
    logic                                r_out_bwd;
    mdrc_pkg::t_mode                     r_out_mode;

    logic                                advance;
    mdrc_pkg::t_mode                     dir;
    mdrc_pkg::t_duty                     target_clamped;
    mdrc_pkg::t_duty                     target;
    logic [TIME_WIDTH-1:0]               el_stop;
    logic [TIME_WIDTH-1:0]               el_ramp;
    logic [PW-1:0]                       prod;
    logic [PW:0]                         prod_inc;
    logic [PW:0]                         prod_sum;
    mdrc_pkg::t_duty                     quot;
    mdrc_pkg::t_duty                     span;
    logic                                tick;
    logic                                enter_dir;
    logic [DW:0]                         up_sum;
    mdrc_pkg::t_duty                     up_duty;
    mdrc_pkg::t_duty                     down_raw;
    mdrc_pkg::t_duty                     down_duty;
    mdrc_pkg::t_duty                     ramped;

    // Handshake: the stage moves when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    assign o_res.valid          = r_out_valid;
    assign o_res.duty_out       = r_out_duty;
    assign o_res.forward_level  = r_out_fwd;
    assign o_res.backward_level = r_out_bwd;
    assign o_res.motor_mode     = r_out_mode;

    // Decode the command: unused direction code means stop, duty clamped
    assign dir = (r_in_dir == mdrc_pkg::MODE_BAD) ? mdrc_pkg::MODE_STOP : r_in_dir;
    assign target_clamped = r_in_req[mdrc_pkg::REQ_WIDTH-1] ? '0 :
                            (r_in_req[mdrc_pkg::REQ_WIDTH-2:DW] != '0) ? mdrc_pkg::DUTY_MAX :
                            r_in_req[DW-1:0];

    // Elapsed times wrap naturally at the timestamp width
    assign el_stop = r_in_now - r_stop_stamp;
    assign el_ramp = r_in_now - r_ramp_stamp;

    // Tick spacing: interval - floor(interval*duty/255), reciprocal form
    assign prod     = {{DW{1'b0}}, r_interval} * {{DW{1'b0}}, r_duty};
    assign prod_inc = {1'b0, prod} + {{PW{1'b0}}, 1'b1};
    assign prod_sum = prod_inc + (prod_inc >> DW);
    assign quot     = prod_sum[PW-1:DW];
    assign span     = r_interval - quot;
    assign tick     = el_ramp > {{(TIME_WIDTH-DW){1'b0}}, span};

    // Ramp toward the target without passing it
    assign up_sum    = {1'b0, r_duty} + {1'b0, r_up_step};
    assign up_duty   = (up_sum > {1'b0, target}) ? target : up_sum[DW-1:0];
    assign down_raw  = (r_duty >= r_down_step) ? (r_duty - r_down_step) : '0;
    assign down_duty = (down_raw < target) ? target : down_raw;
    assign ramped    = (target > r_duty) ? up_duty :
                       (target < r_duty) ? down_duty : r_duty;

    // Next controller state for the command in the input register
    always_comb begin
        n_mode       = r_mode;
        n_last_dir   = r_last_dir;
        n_duty       = r_duty;
        n_ramp_stamp = r_ramp_stamp;
        n_stop_stamp = r_stop_stamp;
        n_fwd_pin    = r_fwd_pin;
        n_bwd_pin    = r_bwd_pin;
        target       = target_clamped;
        enter_dir    = 1'b0;

        case (r_mode)
            mdrc_pkg::MODE_STOP: begin
                target = '0;
                if (dir == mdrc_pkg::MODE_STOP) begin
                    n_fwd_pin = 1'b0;
                    n_bwd_pin = 1'b0;
                end else if (dir == r_last_dir ||
                             el_stop > {{(TIME_WIDTH-mdrc_pkg::DELAY_WIDTH){1'b0}},
                                        r_rev_delay}) begin
                    enter_dir = 1'b1;
                end
            end
            mdrc_pkg::MODE_FWD: begin
                if (dir != mdrc_pkg::MODE_FWD) begin
                    target = '0;
                end
                n_fwd_pin = 1'b1;
                n_bwd_pin = 1'b0;
            end
            default: begin
                if (dir != mdrc_pkg::MODE_BWD) begin
                    target = '0;
                end
                n_fwd_pin = 1'b0;
                n_bwd_pin = 1'b1;
            end
        endcase

        if (enter_dir) begin
            n_mode = dir;
        end else begin
            if (tick) begin
                n_ramp_stamp = r_in_now;
                n_duty       = ramped;
            end
            // A running motor whose duty reaches zero falls back to stop
            if (n_duty == '0 && r_mode != mdrc_pkg::MODE_STOP) begin
                n_stop_stamp = r_in_now;
                n_last_dir   = r_mode;
                n_mode       = mdrc_pkg::MODE_STOP;
            end
        end
    end

    // Control, state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode       <= mdrc_pkg::MODE_STOP;
            r_last_dir   <= mdrc_pkg::MODE_STOP;
            r_duty       <= '0;
            r_ramp_stamp <= '0;
            r_stop_stamp <= '0;
            r_fwd_pin    <= 1'b0;
            r_bwd_pin    <= 1'b0;
            r_up_step    <= mdrc_pkg::RST_RAMP_UP;
            r_down_step  <= mdrc_pkg::RST_RAMP_DOWN;
            r_rev_delay  <= mdrc_pkg::RST_REV_DELAY;
            r_interval   <= mdrc_pkg::RST_RAMP_INTERVAL;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_mode       <= n_mode;
                r_last_dir   <= n_last_dir;
                r_duty       <= n_duty;
                r_ramp_stamp <= n_ramp_stamp;
                r_stop_stamp <= n_stop_stamp;
                r_fwd_pin    <= n_fwd_pin;
                r_bwd_pin    <= n_bwd_pin;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mdrc_pkg::CFG_RAMP_UP:   r_up_step   <= i_cfg_data[DW-1:0];
                    mdrc_pkg::CFG_RAMP_DOWN: r_down_step <= i_cfg_data[DW-1:0];
                    mdrc_pkg::CFG_REV_DELAY: r_rev_delay <= i_cfg_data;
                    mdrc_pkg::CFG_RAMP_INT:  r_interval  <= i_cfg_data[DW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_req <= i_cmd.requested_duty;
            r_in_dir <= i_cmd.direction;
            r_in_now <= i_cmd.now_ms;
        end
        if (advance) begin
            r_out_duty <= n_duty;
            r_out_fwd  <= n_fwd_pin;
            r_out_bwd  <= n_bwd_pin;
            r_out_mode <= n_mode;
        end
    end

    // The two bridge legs are never driven high together
    a_legs_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fwd_pin && r_bwd_pin))
        else $error("both bridge legs driven high");

    // A stopped motor always carries zero duty
    a_stop_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == mdrc_pkg::MODE_STOP) |-> (r_duty == '0))
        else $error("non-zero duty in stop mode");

    // A held command is not dropped while the result register is stalled
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("pending command lost during stall");

    // The result mode and duty match the state written on the same transfer
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_mode == r_mode && r_out_duty == r_duty))
        else $error("result register disagrees with controller state");

endmodule
